>>> src/sinegen_pkg.sv
package sinegen_pkg;

   localparam int INDEX_BITS_DEFAULT = 12;
   localparam int LEVEL_BITS_DEFAULT = 16;

   localparam int LEN_BITS     = 13;
   localparam int DEPTH_BITS   = 17;
   localparam int PHASE_BITS   = 24;
   localparam int QUARTER_BITS = 22;
   localparam int FRAC_BITS    = 30;
   localparam int SINE_FRAC    = 17;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = 2;
   localparam int POLY_TERMS   = 6;

   localparam logic [LEN_BITS-1:0]   LENGTH_RESET = 13'd16;
   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET  = 17'd16;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'd1073741824;

   // register indexes on the csr port
   localparam logic CSR_TABLE_LENGTH = 1'b0;
   localparam logic CSR_TABLE_DEPTH  = 1'b1;

   // Taylor divisors, innermost first, and floor(2^32 / divisor)
   localparam logic [7:0]  POLY_DIV   [POLY_TERMS] = '{8'd156, 8'd110, 8'd72,
                                                      8'd42, 8'd20, 8'd6};
   localparam logic [29:0] POLY_MAGIC [POLY_TERMS] = '{30'd27531841, 30'd39045157,
                                                      30'd59652323, 30'd102261126,
                                                      30'd214748364, 30'd715827882};

   typedef struct packed {
      logic last;
      logic oor;
   } tag_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] index;
      tag_type             tag;
   } entry_type;

endpackage

>>> src/sine_table_sample_generator.sv
// Unsigned sine wavetable sample generator. Each request carries a sample
// index and returns one sample round(h*sin(2*pi*index/length) + h), with
// h = (depth-1)/2; an index at or beyond table_length returns 0 with
// out_of_range set, and last_sample marks index = table_length-1. The block
// takes one request and gives one response per clock while rsp_ready stays
// high; a response passes through pipelined phase division, quarter-wave
// fold and polynomial, and offset, scaling and saturation, behind a 4-entry
// request queue. csr_index 0 writes table_length, 1 writes table_depth;
// write them only while the block is idle.
module sine_table_sample_generator #(
   parameter int INDEX_BITS = sinegen_pkg::INDEX_BITS_DEFAULT,
   parameter int LEVEL_BITS = sinegen_pkg::LEVEL_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [sinegen_pkg::DEPTH_BITS-1:0] csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [INDEX_BITS-1:0]   req_sample_index,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [LEVEL_BITS-1:0]   rsp_sample_value,
   output logic                    rsp_last_sample,
   output logic                    rsp_out_of_range
);
   import sinegen_pkg::*;

   logic [LEN_BITS-1:0]   length_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic                  q_valid, q_ready;
   entry_type             q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
         depth_ff  <= DEPTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TABLE_LENGTH: length_ff <= csr_wdata[LEN_BITS-1:0];
            CSR_TABLE_DEPTH:  depth_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   sinegen_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .table_length     (length_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_entry          (q_entry)
   );

   sinegen_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .table_length (length_ff),
      .table_depth  (depth_ff),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_entry     (q_entry),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_value    (rsp_sample_value),
      .out_last     (rsp_last_sample),
      .out_oor      (rsp_out_of_range)
   );

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_sample_value == '0)
      else $error("out-of-range response with nonzero sample");

   a_last_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_sample |-> !rsp_out_of_range)
      else $error("last sample flagged out of range");

endmodule

>>> src/sinegen_front.sv
module sinegen_front #(
   parameter int INDEX_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sinegen_pkg::LEN_BITS-1:0] table_length,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [INDEX_BITS-1:0]        req_sample_index,
   output logic                         q_valid,
   input  logic                         q_ready,
   output sinegen_pkg::entry_type       q_entry
);
   import sinegen_pkg::*;

   localparam int CW = (INDEX_BITS > LEN_BITS ? INDEX_BITS : LEN_BITS) + 1;

   entry_type             mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]    count_ff, count_in;
   logic [CW-1:0]         idx_ext, len_ext;
   entry_type             entry_in;
   logic                  push, pop;

   assign idx_ext = CW'(req_sample_index);
   assign len_ext = CW'(table_length);

   always_comb begin
      entry_in.index    = LEN_BITS'(req_sample_index);
      entry_in.tag.oor  = idx_ext >= len_ext;
      entry_in.tag.last = (idx_ext + CW'(1)) == len_ext;
   end

   assign req_ready = count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign q_valid   = count_ff != '0;
   assign q_entry   = mem[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= entry_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a request");

endmodule

>>> src/sinegen_back.sv
module sinegen_back #(
   parameter int LEVEL_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sinegen_pkg::LEN_BITS-1:0]   table_length,
   input  logic [sinegen_pkg::DEPTH_BITS-1:0] table_depth,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  sinegen_pkg::entry_type          in_entry,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [LEVEL_BITS-1:0]           out_value,
   output logic                            out_last,
   output logic                            out_oor
);
   import sinegen_pkg::*;

   localparam int DIV_STAGES  = PHASE_BITS;
   localparam int POLY_STEPS  = 3 * POLY_TERMS;
   localparam int POLY_REGS   = POLY_STEPS + 2;
   localparam int NS          = DIV_STAGES + POLY_REGS + 4;
   localparam int VW          = 19;
   localparam int SW          = (LEVEL_BITS > VW ? LEVEL_BITS : VW);

   typedef struct packed {
      logic [LEN_BITS-1:0]   rem;
      logic [PHASE_BITS-1:0] quo;
      tag_type               tag;
   } div_type;

   typedef struct packed {
      logic [30:0] u;
      logic [31:0] u2;
      logic [30:0] acc;
      logic [31:0] p;
      logic [29:0] q0;
      logic [1:0]  quad;
      tag_type     tag;
   } poly_type;

   logic [NS-1:0]          vld_ff;
   div_type                div_ff  [DIV_STAGES+1];
   poly_type               poly_ff [POLY_REGS];
   logic [VW-1:0]          so_ff;
   tag_type                so_tag_ff;
   logic [35:0]            prod_ff;
   tag_type                prod_tag_ff;
   logic [LEVEL_BITS-1:0]  value_ff, value_in;
   tag_type                out_tag_ff;
   logic                   adv;

   assign adv       = !vld_ff[NS-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[NS-1];
   assign out_value = value_ff;
   assign out_last  = out_tag_ff.last;
   assign out_oor   = out_tag_ff.oor;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   // load divider: remainder starts at the index, below the length when in range
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0].rem <= in_entry.index;
         div_ff[0].quo <= '0;
         div_ff[0].tag <= in_entry.tag;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      logic [LEN_BITS:0] twice;
      logic              ge;
      div_type           div_in;
      always_comb begin
         twice      = {div_ff[d].rem, 1'b0};
         ge         = twice >= {1'b0, table_length};
         div_in.rem = ge ? LEN_BITS'(twice - {1'b0, table_length}) : LEN_BITS'(twice);
         div_in.quo = {div_ff[d].quo[PHASE_BITS-2:0], ge};
         div_in.tag = div_ff[d].tag;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[d+1] <= div_in;
         end
      end
   end

   // fold into the first quarter wave and scale by pi/2
   logic [QUARTER_BITS:0] fold_x;
   logic [53:0]           fold_prod;
   poly_type              fold_in;
   always_comb begin
      fold_x = div_ff[DIV_STAGES].quo[QUARTER_BITS] ?
               ((QUARTER_BITS+1)'(1) << QUARTER_BITS) -
               {1'b0, div_ff[DIV_STAGES].quo[QUARTER_BITS-1:0]} :
               {1'b0, div_ff[DIV_STAGES].quo[QUARTER_BITS-1:0]};
      fold_prod    = 54'(fold_x) * 54'(HALF_PI_Q30);
      fold_in      = '0;
      fold_in.u    = fold_prod[52:22];
      fold_in.quad = div_ff[DIV_STAGES].quo[PHASE_BITS-1:QUARTER_BITS];
      fold_in.tag  = div_ff[DIV_STAGES].tag;
   end

   logic [61:0] sq_prod;
   poly_type    sq_in;
   always_comb begin
      sq_prod   = 62'(poly_ff[0].u) * 62'(poly_ff[0].u);
      sq_in     = poly_ff[0];
      sq_in.u2  = sq_prod[61:30];
      sq_in.acc = ONE_Q30;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         poly_ff[0] <= fold_in;
         poly_ff[1] <= sq_in;
      end
   end

   // nested Horner steps: multiply, reciprocal multiply, correct and subtract
   for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
      localparam int K  = j / 3;
      localparam int PH = j % 3;
      poly_type    poly_in;
      logic [62:0] mul;
      logic [31:0] rest;
      logic [29:0] q;
      always_comb begin
         poly_in = poly_ff[j+1];
         mul     = '0;
         rest    = '0;
         q       = '0;
         if (PH == 0) begin
            mul       = 63'(poly_ff[j+1].u2) * 63'(poly_ff[j+1].acc);
            poly_in.p = mul[61:30];
         end else if (PH == 1) begin
            mul        = 63'(poly_ff[j+1].p) * 63'(POLY_MAGIC[K]);
            poly_in.q0 = mul[61:32];
         end else begin
            rest = poly_ff[j+1].p - 32'(poly_ff[j+1].q0) * 32'(POLY_DIV[K]);
            q    = poly_ff[j+1].q0 + 30'(rest >= 32'(POLY_DIV[K]));
            poly_in.acc = (31'(q) >= ONE_Q30) ? '0 : ONE_Q30 - 31'(q);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            poly_ff[j+2] <= poly_in;
         end
      end
   end

   // final odd factor, round to Q1.17 and offset by one
   logic [61:0]   fin_prod;
   logic [30:0]   fin_clamp;
   logic [18:0]   mag;
   logic [VW-1:0] so_in;
   always_comb begin
      fin_prod  = 62'(poly_ff[POLY_REGS-1].u) * 62'(poly_ff[POLY_REGS-1].acc);
      fin_clamp = (fin_prod[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : fin_prod[60:30];
      mag       = 19'((32'(fin_clamp) + 32'd4096) >> (FRAC_BITS - SINE_FRAC));
      if (mag > 19'(1 << SINE_FRAC)) begin
         mag = 19'(1 << SINE_FRAC);
      end
      so_in = poly_ff[POLY_REGS-1].quad[1] ? VW'(1 << SINE_FRAC) - mag
                                             : VW'(1 << SINE_FRAC) + mag;
   end

   logic [DEPTH_BITS-1:0] dm1;
   assign dm1 = (table_depth == '0) ? '0 : table_depth - 1'b1;

   logic [36:0]   sum;
   logic [VW-1:0] v;
   always_comb begin
      sum = 37'(prod_ff) + 37'(1 << SINE_FRAC);
      v   = sum[36:18];
      if (prod_tag_ff.oor) begin
         value_in = '0;
      end else if (SW'(v) > SW'({LEVEL_BITS{1'b1}})) begin
         value_in = '1;
      end else begin
         value_in = LEVEL_BITS'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         so_ff       <= so_in;
         so_tag_ff   <= poly_ff[POLY_REGS-1].tag;
         prod_ff     <= 36'(dm1) * 36'(so_ff);
         prod_tag_ff <= so_tag_ff;
         value_ff    <= value_in;
         out_tag_ff  <= prod_tag_ff;
      end
   end

endmodule
